### hdl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Shared constants, status codes and types of the LZSS ring unpacker.
// ----------------------------------------------------------------------------
package lru_pkg;

  // history ring, match chunk, flag store, group and header sizes
  localparam int RING_DEPTH  = 2048;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int CHUNK_DEPTH = 256;
  localparam int CHUNK_AW    = $clog2(CHUNK_DEPTH);
  localparam int FLAG_DEPTH  = 8192;
  localparam int FLAG_AW     = $clog2(FLAG_DEPTH);
  localparam int GROUP_BYTES = 8;
  localparam int GROUP_W     = 8 * GROUP_BYTES;
  localparam int FILL_W      = $clog2(GROUP_BYTES) + 1;
  localparam int HDR_BYTES   = 9;
  localparam logic [7:0] PACK_MARK = 8'hFF;

  // file sections
  localparam logic [1:0] SEC_HDR   = 2'd0;
  localparam logic [1:0] SEC_FLAG  = 2'd1;
  localparam logic [1:0] SEC_TOK   = 2'd2;
  localparam logic [1:0] SEC_TRAIL = 2'd3;

  // final status codes
  localparam logic [3:0] STAT_OK         = 4'd0;
  localparam logic [3:0] STAT_NOT_PACKED = 4'd1;
  localparam logic [3:0] STAT_TRUNC      = 4'd2;
  localparam logic [3:0] STAT_FLAG_SHORT = 4'd3;
  localparam logic [3:0] STAT_FLAG_CNT   = 4'd4;
  localparam logic [3:0] STAT_TRAILING   = 4'd5;
  localparam logic [3:0] STAT_MATCH_OVR  = 4'd6;
  localparam logic [3:0] STAT_MATCH_SIZE = 4'd7;
  localparam logic [3:0] STAT_LIT_OVR    = 4'd8;
  localparam logic [3:0] STAT_TOK_CNT    = 4'd9;
  localparam logic [3:0] STAT_SIZE       = 4'd10;

  // one result pushed from the control into the output stage
  typedef struct packed {
    logic               valid;
    logic [GROUP_W-1:0] data;
    logic [3:0]         count;
    logic               last;
    logic [3:0]         status;
  } out_push_t;

endpackage

### hdl/lru_ram.sv
// ----------------------------------------------------------------------------
// lru_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lru_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered, old data on collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/lru_ctrl.sv
// ----------------------------------------------------------------------------
// lru_ctrl
// Byte sequencer: header parse, flag store, token decode and match copy
// through the history ring and the chunk buffer.
// ----------------------------------------------------------------------------
module lru_ctrl
  import lru_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_byte,
  input  logic      in_last,
  input  logic      ofree,
  output out_push_t push
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOOK  = 4'd1;
  localparam logic [3:0] ST_EXEC  = 4'd2;
  localparam logic [3:0] ST_CRD   = 4'd3;
  localparam logic [3:0] ST_CWAIT = 4'd4;
  localparam logic [3:0] ST_CWRD  = 4'd5;
  localparam logic [3:0] ST_CWEM  = 4'd6;
  localparam logic [3:0] ST_FLOOK = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [3:0]          st;
  logic [7:0]          cur_b;
  logic                cur_last;
  logic [1:0]          sect;
  logic [16:0]         pos;
  logic                np;
  logic                trail;
  logic                hok;
  logic [15:0]         hdr [4];
  logic [15:0]         hdr_next [4];
  logic [15:0]         tok_idx;
  logic [16:0]         tok_off;
  logic [15:0]         pend;
  logic [1:0]          mph;
  logic [16:0]         produced;
  logic [GROUP_W-1:0]  gbuf;
  logic [FILL_W-2:0]   gfill;
  logic [3:0]          err;
  logic [RING_AW-1:0]  wp;
  logic [8:0]          clen;
  logic [8:0]          cidx;
  logic                rd_v;
  logic                rd_ok;
  logic [CHUNK_AW-1:0] rd_i;

  logic [7:0]          flag_q;
  logic [7:0]          ring_q;
  logic [7:0]          chunk_q;
  logic                fbit;
  logic                exec_go;
  logic                fin_go;
  logic                dec_en;
  logic                lit_ok;
  logic                copy_go;
  logic                emit_en;
  logic [7:0]          emit_b;
  logic [GROUP_W-1:0]  gbuf_ins;
  logic [8:0]          mlen;
  logic [16:0]         remain;
  logic                np_next;
  logic [16:0]         pos_inc;
  logic                hok_next;
  logic [RING_AW-1:0]  src_addr;
  logic                src_ok;
  logic [3:0]          status;

  assign in_ready = (st == ST_IDLE);
  assign exec_go  = (st == ST_EXEC) && ofree;
  assign fin_go   = (st == ST_FIN) && ofree;
  assign fbit     = flag_q[3'd7 - tok_idx[2:0]];
  assign dec_en   = (sect == SEC_TOK) && hok && (err == STAT_OK) && (tok_idx < hdr[2]);
  assign mlen     = {1'b0, cur_b} + 9'd1;
  assign remain   = {1'b0, hdr[0]} - produced;
  assign lit_ok   = dec_en && !fbit && (produced < {1'b0, hdr[0]});
  assign copy_go  = exec_go && dec_en && fbit && (mph == 2'd2) &&
                    !({8'd0, mlen} > remain);
  assign emit_en  = (exec_go && lit_ok) || ((st == ST_CWEM) && ofree);
  assign emit_b   = (st == ST_CWEM) ? chunk_q : cur_b;
  assign pos_inc  = pos + 17'd1;

  // ring source address and whether that entry was written in this file
  assign src_addr = pend[RING_AW-1:0] + RING_AW'(cidx);
  assign src_ok   = (produced >= 17'(RING_DEPTH)) || (src_addr < wp);

  // insert the emitted byte into the group
  always_comb begin
    gbuf_ins = gbuf;
    gbuf_ins[{gfill, 3'b000} +: 8] = emit_b;
  end

  // header words after the current header byte
  always_comb begin
    np_next = np || ((pos == 17'd0) && (cur_b != PACK_MARK));
    for (int i = 0; i < 4; i++) begin
      hdr_next[i] = hdr[i];
    end
    if (!np_next && (pos >= 17'd1) && (pos < 17'(HDR_BYTES))) begin
      if (pos[0]) begin
        hdr_next[pos[2:1]] = {8'd0, cur_b};
      end else begin
        hdr_next[pos[2:1] - 2'd1][15:8] = cur_b;
      end
    end
    hok_next = ({3'd0, hdr_next[2]} <= {hdr_next[3], 3'b000}) &&
               ({1'b0, hdr_next[3]} == (({1'b0, hdr_next[2]} + 17'd7) >> 3));
  end

  // final status, first failing check wins
  always_comb begin
    priority if (sect == SEC_HDR) begin
      status = STAT_NOT_PACKED;
    end else if (sect != SEC_TRAIL) begin
      status = STAT_TRUNC;
    end else if ({3'd0, hdr[2]} > {hdr[3], 3'b000}) begin
      status = STAT_FLAG_SHORT;
    end else if ({1'b0, hdr[3]} != (({1'b0, hdr[2]} + 17'd7) >> 3)) begin
      status = STAT_FLAG_CNT;
    end else if (trail) begin
      status = STAT_TRAILING;
    end else if (err != STAT_OK) begin
      status = err;
    end else if (tok_idx < hdr[2]) begin
      status = fbit ? STAT_MATCH_OVR : STAT_LIT_OVR;
    end else if (tok_off != {1'b0, hdr[1]}) begin
      status = STAT_TOK_CNT;
    end else if (produced != {1'b0, hdr[0]}) begin
      status = STAT_SIZE;
    end else begin
      status = STAT_OK;
    end
  end

  // result push: full group or final result
  always_comb begin
    push.valid  = 1'b0;
    push.data   = gbuf_ins;
    push.count  = 4'(GROUP_BYTES);
    push.last   = 1'b0;
    push.status = STAT_OK;
    if (fin_go) begin
      push.valid  = 1'b1;
      push.data   = gbuf;
      push.count  = 4'(gfill);
      push.last   = 1'b1;
      push.status = status;
    end else if (emit_en && (gfill == (FILL_W-1)'(GROUP_BYTES - 1))) begin
      push.valid = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      unique case (st)
        ST_IDLE:  if (in_valid) st <= ST_LOOK;
        ST_LOOK:  st <= ST_EXEC;
        ST_EXEC: begin
          if (ofree) begin
            if (copy_go) st <= ST_CRD;
            else         st <= cur_last ? ST_FLOOK : ST_IDLE;
          end
        end
        ST_CRD:   if (cidx == clen - 9'd1) st <= ST_CWAIT;
        ST_CWAIT: st <= ST_CWRD;
        ST_CWRD:  st <= ST_CWEM;
        ST_CWEM: begin
          if (ofree) begin
            if (cidx == clen - 9'd1) st <= cur_last ? ST_FLOOK : ST_IDLE;
            else                     st <= ST_CWRD;
          end
        end
        ST_FLOOK: st <= ST_FIN;
        ST_FIN:   if (ofree) st <= ST_IDLE;
        default:  st <= ST_IDLE;
      endcase
    end
  end

  // accepted item and copy counters
  always_ff @(posedge clk) begin
    if (st == ST_IDLE && in_valid) begin
      cur_b    <= in_byte;
      cur_last <= in_last;
    end
    if (copy_go) begin
      clen <= mlen;
      cidx <= 9'd0;
    end else if (st == ST_CRD) begin
      cidx <= (cidx == clen - 9'd1) ? 9'd0 : cidx + 9'd1;
    end else if (st == ST_CWEM && ofree) begin
      cidx <= cidx + 9'd1;
    end
    rd_i  <= cidx[CHUNK_AW-1:0];
    rd_ok <= src_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_v <= 1'b0;
    else     rd_v <= (st == ST_CRD);
  end

  // file state, cleared on reset and after each final result
  always_ff @(posedge clk) begin
    if (rst || fin_go) begin
      sect     <= SEC_HDR;
      pos      <= '0;
      np       <= 1'b0;
      trail    <= 1'b0;
      hok      <= 1'b0;
      for (int i = 0; i < 4; i++) hdr[i] <= '0;
      tok_idx  <= '0;
      tok_off  <= '0;
      pend     <= '0;
      mph      <= '0;
      produced <= '0;
      gbuf     <= '0;
      gfill    <= '0;
      err      <= STAT_OK;
      wp       <= '0;
    end else begin
      if (emit_en) begin
        wp       <= wp + RING_AW'(1);
        produced <= produced + 17'd1;
        gfill    <= gfill + (FILL_W-1)'(1);
        gbuf     <= (gfill == (FILL_W-1)'(GROUP_BYTES - 1)) ? '0 : gbuf_ins;
      end
      if (exec_go) begin
        unique case (sect)
          SEC_HDR: begin
            np <= np_next;
            for (int i = 0; i < 4; i++) hdr[i] <= hdr_next[i];
            if (!np_next && (pos + 17'd1 == 17'(HDR_BYTES))) begin
              hok <= hok_next;
              pos <= '0;
              if (hdr_next[3] == 16'd0) begin
                sect <= (hdr_next[1] == 16'd0) ? SEC_TRAIL : SEC_TOK;
              end else begin
                sect <= SEC_FLAG;
              end
            end else if (pos < 17'(HDR_BYTES)) begin
              pos <= pos_inc;
            end
          end
          SEC_FLAG: begin
            if (pos_inc >= {1'b0, hdr[3]}) begin
              pos  <= '0;
              sect <= (hdr[1] == 16'd0) ? SEC_TRAIL : SEC_TOK;
            end else begin
              pos <= pos_inc;
            end
          end
          SEC_TOK: begin
            if (dec_en) begin
              if (fbit) begin
                unique case (mph)
                  2'd0: begin
                    pend <= {8'd0, cur_b};
                    mph  <= 2'd1;
                  end
                  2'd1: begin
                    pend[15:8] <= cur_b;
                    mph        <= 2'd2;
                  end
                  default: begin
                    mph     <= 2'd0;
                    tok_off <= tok_off + 17'd3;
                    tok_idx <= tok_idx + 16'd1;
                    if ({8'd0, mlen} > remain) err <= STAT_MATCH_SIZE;
                  end
                endcase
              end else if (lit_ok) begin
                tok_off <= tok_off + 17'd1;
                tok_idx <= tok_idx + 16'd1;
              end else begin
                err <= STAT_LIT_OVR;
              end
            end
            pos <= pos_inc;
            if (pos_inc >= {1'b0, hdr[1]}) sect <= SEC_TRAIL;
          end
          SEC_TRAIL: trail <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // flag store, read continuously at the current token
  lru_ram #(.DEPTH(FLAG_DEPTH), .WIDTH(8)) u_flag (
    .clk   (clk),
    .we    (exec_go && (sect == SEC_FLAG) && (pos < 17'(FLAG_DEPTH))),
    .waddr (pos[FLAG_AW-1:0]),
    .wdata (cur_b),
    .raddr (tok_idx[15:3]),
    .rdata (flag_q)
  );

  // history ring
  lru_ram #(.DEPTH(RING_DEPTH), .WIDTH(8)) u_ring (
    .clk   (clk),
    .we    (emit_en),
    .waddr (wp),
    .wdata (emit_b),
    .raddr (src_addr),
    .rdata (ring_q)
  );

  // match chunk: whole match read from the old ring before write-back
  lru_ram #(.DEPTH(CHUNK_DEPTH), .WIDTH(8)) u_chunk (
    .clk   (clk),
    .we    (rd_v),
    .waddr (rd_i),
    .wdata (rd_ok ? ring_q : 8'd0),
    .raddr (cidx[CHUNK_AW-1:0]),
    .rdata (chunk_q)
  );

  // no ring write while the chunk is being gathered
  a_no_emit_in_gather: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CRD || st == ST_CWAIT) |-> !emit_en)
    else $error("ring written during match gather");

  // gather index stays inside the match
  a_gather_idx: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CRD) |-> (cidx < clen))
    else $error("match gather index out of range");

  // chunk writes come only in the cycle after a gather step
  a_chunk_wr: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (st == ST_CRD || st == ST_CWAIT))
    else $error("chunk written outside the gather");

endmodule

### hdl/lzss_ring_unpacker_top.sv
// ----------------------------------------------------------------------------
// lzss_ring_unpacker_top
// LZSS unpacker with a 2 KiB history ring; decoded bytes leave in groups.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)              | tlast
//  s_*     | in  | in_byte[7:0]                           | in_last
//  m_*     | out | out_data[63:0] out_count[3:0] status   | out_last
//
//  Header, flag and literal bytes pass IDLE, LOOK and EXEC (LOOK covers the flag store read).
//  A match then gathers through the ring port (CRD, CWAIT) and replays each
//  byte from the chunk buffer (CWRD, CWEM). The final result passes FLOOK and FIN.
//  rst is synchronous; no clearing pass, the ring uses a fill count per file.
//  A stalled output holds the sequencer wherever it would push a result.
module lzss_ring_unpacker_top
  import lru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_data[63:0], out_count[67:64], out_status[71:68]
  output logic        m_tlast
);

  out_push_t push;
  logic      ofree;

  assign ofree = !m_tvalid || m_tready;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .ofree    (ofree),
    .push     (push)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ofree) begin
      m_tvalid <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ofree && push.valid) begin
      m_tdata <= {push.status, push.count, push.data};
      m_tlast <= push.last;
    end
  end

  // results other than the final one are full groups
  a_full_group: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[67:64] == 4'(GROUP_BYTES)))
    else $error("partial group before final result");

  // a push is only offered when the output register can take it
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> ofree)
    else $error("result pushed into a full output register");

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while stalled");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the LZSS ring unpacker: packed files go in byte by byte, decoded
// groups and the final status are checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top
  import lru_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // in_byte
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // out_data[63:0], out_count[67:64], out_status[71:68]
  logic        m_tlast;

  lzss_ring_unpacker_top DUT (.*);

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [3:0]  status;
  } group_t;

  // predictor state
  logic [7:0]  ring_m [RING_DEPTH];
  logic [7:0]  flags_m [FLAG_DEPTH];
  logic [7:0]  chunk_m [CHUNK_DEPTH];
  logic [15:0] hdr_m [4];
  int unsigned wptr_m, pos_m, tok_idx_m, tok_off_m, src_m, phase_m, made_m;
  int unsigned fill_m, err_m;
  logic [1:0]  sec_m;
  logic [63:0] grp_m;
  bit          notpk_m, trail_m, hdr_ok_m;

  group_t      expected_q[$];
  int          errors;
  int          n_groups, n_files, n_sent;
  int          idle_cycles;

  // sender burst shaping
  int burst_left;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic unpack_clear();
    foreach (ring_m[i]) ring_m[i] = 0;
    foreach (flags_m[i]) flags_m[i] = 0;
    foreach (hdr_m[i]) hdr_m[i] = 0;
    wptr_m = 0; pos_m = 0; sec_m = SEC_HDR; tok_idx_m = 0; tok_off_m = 0;
    src_m = 0; phase_m = 0; made_m = 0; grp_m = 0; fill_m = 0; err_m = 0;
    notpk_m = 0; trail_m = 0; hdr_ok_m = 0;
  endtask

  task automatic emit_byte(logic [7:0] b);
    group_t g;
    ring_m[wptr_m] = b;
    wptr_m = (wptr_m + 1) % RING_DEPTH;
    made_m++;
    grp_m |= 64'(b) << (8 * fill_m);
    fill_m++;
    if (fill_m >= GROUP_BYTES) begin
      g.data = grp_m; g.count = 4'(fill_m); g.last = 0; g.status = STAT_OK;
      expected_q = {expected_q, g};
      grp_m = 0; fill_m = 0;
    end
  endtask

  function automatic bit is_match(int unsigned idx);
    if ((idx >> 3) >= FLAG_DEPTH) return 0;
    return flags_m[idx >> 3][7 - (idx & 7)];
  endfunction

  task automatic enter_tokens();
    sec_m = SEC_TOK; pos_m = 0;
    if (hdr_m[1] == 0) sec_m = SEC_TRAIL;
  endtask

  task automatic decode_token(logic [7:0] b);
    int unsigned len;
    if (is_match(tok_idx_m)) begin
      if (phase_m == 0) begin
        src_m = b; phase_m = 1;
      end else if (phase_m == 1) begin
        src_m |= b << 8; phase_m = 2;
      end else begin
        len = b + 1; phase_m = 0; tok_off_m += 3; tok_idx_m++;
        if (len > 32'(hdr_m[0]) - made_m) begin
          err_m = STAT_MATCH_SIZE;
          return;
        end
        for (int i = 0; i < len; i++) chunk_m[i] = ring_m[(src_m + i) % RING_DEPTH];
        for (int i = 0; i < len; i++) emit_byte(chunk_m[i]);
      end
    end else begin
      if (made_m >= hdr_m[0]) begin
        err_m = STAT_LIT_OVR;
        return;
      end
      emit_byte(b); tok_off_m++; tok_idx_m++;
    end
  endtask

  function automatic logic [3:0] file_status();
    int unsigned tc, fb;
    tc = hdr_m[2]; fb = hdr_m[3];
    if (sec_m == SEC_HDR) return STAT_NOT_PACKED;
    if (sec_m != SEC_TRAIL) return STAT_TRUNC;
    if (tc > fb * 8) return STAT_FLAG_SHORT;
    if (fb != (tc + 7) / 8) return STAT_FLAG_CNT;
    if (trail_m) return STAT_TRAILING;
    if (err_m != 0) return 4'(err_m);
    if (tok_idx_m < tc) return is_match(tok_idx_m) ? STAT_MATCH_OVR : STAT_LIT_OVR;
    if (tok_off_m != hdr_m[1]) return STAT_TOK_CNT;
    if (made_m != hdr_m[0]) return STAT_SIZE;
    return STAT_OK;
  endfunction

  // advance the predictor by one accepted input byte
  task automatic unpack_byte(logic [7:0] b, logic last);
    group_t g;
    int unsigned tc, fb;
    case (sec_m)
      SEC_HDR: begin
        if (pos_m == 0 && b != PACK_MARK) notpk_m = 1;
        if (!notpk_m && pos_m >= 1 && pos_m < HDR_BYTES) begin
          if (((pos_m - 1) & 1) == 0) hdr_m[(pos_m - 1) >> 1] = 16'(b);
          else hdr_m[(pos_m - 1) >> 1][15:8] = b;
        end
        if (pos_m < HDR_BYTES) pos_m++;
        if (!notpk_m && pos_m == HDR_BYTES) begin
          tc = hdr_m[2]; fb = hdr_m[3];
          hdr_ok_m = (tc <= fb * 8) && (fb == (tc + 7) / 8);
          sec_m = SEC_FLAG; pos_m = 0;
          if (fb == 0) enter_tokens();
        end
      end
      SEC_FLAG: begin
        if (pos_m < FLAG_DEPTH) flags_m[pos_m] = b;
        pos_m++;
        if (pos_m >= hdr_m[3]) enter_tokens();
      end
      SEC_TOK: begin
        if (hdr_ok_m && err_m == 0 && tok_idx_m < hdr_m[2]) decode_token(b);
        pos_m++;
        if (pos_m >= hdr_m[1]) sec_m = SEC_TRAIL;
      end
      default: trail_m = 1;
    endcase
    if (last) begin
      g.data = grp_m; g.count = 4'(fill_m); g.last = 1; g.status = file_status();
      expected_q = {expected_q, g};
      unpack_clear();
    end
  endtask

  // send one byte; sender idles in bursts with gaps
  task automatic send_byte(logic [7:0] b, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1; s_tdata <= b; s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    unpack_byte(b, last);
    n_sent++;
    @(negedge clk);
  endtask

  // one packed file built from a byte list
  task automatic send_file(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    n_files++;
  endtask

  function automatic void put16(ref logic [7:0] q[$], input int unsigned v);
    q = {q, v[7:0], v[15:8]};
  endfunction

  // random well formed file, optionally broken; returns bytes
  task automatic make_file(int ntok, int breakage, output logic [7:0] f[$]);
    logic [7:0] toks[$];
    logic [7:0] fl[$];
    int unsigned size;
    bit m;
    size = 0;
    fl = {};
    toks = {};
    for (int t = 0; t < ntok; t++) begin
      if (t % 8 == 0) fl = {fl, 8'h00};
      m = ($urandom_range(0, 3) == 0) && t > 0;
      if (m) begin
        fl[t / 8][7 - t % 8] = 1;
        put16(toks, $urandom);
        toks = {toks, 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12))};
        size += toks[$] + 1;
      end else begin
        toks = {toks, 8'($urandom)};
        size++;
      end
    end
    case (breakage)
      1: size = size - $urandom_range(0, 3);
      2: size = size + $urandom_range(1, 3);
      default: ;
    endcase
    f = {PACK_MARK};
    put16(f, size); put16(f, toks.size()); put16(f, ntok); put16(f, fl.size());
    f = {f, fl, toks};
    case (breakage)
      3: f = {f, 8'($urandom)};
      4: f = f[0:$urandom_range(0, f.size() - 2)];
      5: f[$urandom_range(0, f.size() - 1)] = 8'($urandom);
      default: ;
    endcase
  endtask

  // wait until every expected result has arrived
  task automatic drain();
    s_tvalid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic test_headers();
    send_file({8'h00});
    send_file({PACK_MARK, 8'h01});
    send_file({8'h12, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_file({PACK_MARK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    // flags short, then flag count mismatch with a trailing byte
    send_file({PACK_MARK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'h01, 8'h00,
               8'h00});
    send_file({PACK_MARK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00,
               8'h00, 8'h00});
    drain();
  endtask

  task automatic test_tokens();
    // literals then a max-length match from the ring, source with high bits set
    send_file({PACK_MARK, 8'h06, 8'h01, 8'h05, 8'h00, 8'h03, 8'h00, 8'h01, 8'h00,
               8'h20, 8'hAB, 8'hCD, 8'hFF, 8'hFF, 8'hFF});
    // match exceeding size, literal overrun, extra token bytes, size mismatch
    send_file({PACK_MARK, 8'h02, 8'h00, 8'h04, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00,
               8'h40, 8'h55, 8'h00, 8'h00, 8'h07});
    send_file({PACK_MARK, 8'h01, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00,
               8'h00, 8'h11, 8'h22});
    send_file({PACK_MARK, 8'h01, 8'h00, 8'h03, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
               8'h00, 8'h33, 8'h44, 8'h55});
    send_file({PACK_MARK, 8'h09, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
               8'h00, 8'h66});
    drain();
  endtask

  task automatic test_random();
    logic [7:0] f[$];
    while (n_sent < 320) begin
      make_file($urandom_range(1, 24), $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 5),
                f);
      send_file(f);
    end
    drain();
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) m_tready <= 1;
    else m_tready <= (($urandom_range(0, 63) < 40) ? 1'b1 : ($urandom_range(0, 3) == 0));
  end

  // result checker
  always @(posedge clk) begin
    group_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got.data = m_tdata[63:0]; got.count = m_tdata[67:64];
      got.status = m_tdata[71:68]; got.last = m_tlast;
      n_groups++;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
      end else begin
        exp = expected_q.pop_front();
        if (got.data != exp.data) begin
          $error("out_data exp %h got %h", exp.data, got.data); errors++;
        end
        if (got.count != exp.count) begin
          $error("out_count exp %0d got %0d", exp.count, got.count); errors++;
        end
        if (got.last != exp.last) begin
          $error("out_last exp %0d got %0d", exp.last, got.last); errors++;
        end
        if (got.status != exp.status) begin
          $error("out_status exp %0d got %0d", exp.status, got.status); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 1;
    errors = 0; n_groups = 0; n_files = 0; n_sent = 0; idle_cycles = 0;
    burst_left = 0;
    unpack_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_headers();
    test_tokens();
    test_random();
    $display("Covered %0d files, %0d bytes in, %0d results out.", n_files, n_sent, n_groups);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
